// ===== hdl/tfbgra_pkg.sv =====
// shared types, format codes and channel widening functions for the texel unpacker
package tfbgra_pkg;

	// source layout codes, as written to the format register
	localparam logic [3:0] FMT_8888   = 4'd0;
	localparam logic [3:0] FMT_X888   = 4'd1;
	localparam logic [3:0] FMT_888    = 4'd2;
	localparam logic [3:0] FMT_565    = 4'd3;
	localparam logic [3:0] FMT_X555   = 4'd4;
	localparam logic [3:0] FMT_1555   = 4'd5;
	localparam logic [3:0] FMT_4444   = 4'd6;
	localparam logic [3:0] FMT_X444   = 4'd7;
	localparam logic [3:0] FMT_A8     = 4'd8;
	localparam logic [3:0] FMT_L8     = 4'd9;
	localparam logic [3:0] FMT_A8L8   = 4'd10;
	localparam logic [3:0] FMT_A4L4   = 4'd11;
	localparam logic [3:0] FMT_332    = 4'd12;
	localparam logic [3:0] FMT_A8_332 = 4'd13;

	localparam int unsigned FMT_W = 4;

	// input word
	typedef struct packed {
		logic [31:0] pixel_bytes;
		logic        last_in;
	} pixel_in_t;

	// result word
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic [2:0] bytes_used;
		logic       format_error;
		logic       last_out;
	} pixel_out_t;

	// 4-bit to 8-bit by replication
	function automatic logic [7:0] rep4(input logic [3:0] v);
		rep4 = {v, v};
	endfunction

	// 5-bit to 8-bit by replication
	function automatic logic [7:0] rep5(input logic [4:0] v);
		rep5 = {v, v[4:2]};
	endfunction

	// floor(x*255/63) = 4x + floor(x/21)
	function automatic logic [7:0] scale6(input logic [5:0] v);
		logic [1:0] corr;
		corr = (v == 6'd63) ? 2'd3 : (v >= 6'd42) ? 2'd2 : (v >= 6'd21) ? 2'd1 : 2'd0;
		scale6 = {v, 2'b00} + {6'd0, corr};
	endfunction

	// floor(x*255/7)
	function automatic logic [7:0] scale3(input logic [2:0] v);
		case (v)
			3'd0:    scale3 = 8'd0;
			3'd1:    scale3 = 8'd36;
			3'd2:    scale3 = 8'd72;
			3'd3:    scale3 = 8'd109;
			3'd4:    scale3 = 8'd145;
			3'd5:    scale3 = 8'd182;
			3'd6:    scale3 = 8'd218;
			default: scale3 = 8'd255;
		endcase
	endfunction

	// x*255/3, exact
	function automatic logic [7:0] scale2(input logic [1:0] v);
		case (v)
			2'd0:    scale2 = 8'd0;
			2'd1:    scale2 = 8'd85;
			2'd2:    scale2 = 8'd170;
			default: scale2 = 8'd255;
		endcase
	endfunction

endpackage

// ===== hdl/texel_format_to_bgra8.sv =====
// texel unpacker: one source pixel in, one bgra8 word out
//
// Usage: the source channel (src_valid / src_ready / src_data) carries one
// pixel per word: up to four little-endian bytes plus a last marker. The
// result channel (dst_valid / dst_ready / dst_data) returns blue, green, red
// and alpha bytes, the source byte count and an error flag for the two
// unsupported format codes. The layout is chosen by fmt_we / fmt_wdata, to
// be written only while no word is in flight.
// Pipeline: two register stages (input register, then the result register
// after a single pass of unpack logic); dst_valid is that register's valid.
// Throughput: one word per cycle while dst_ready is high, set by the
// two-register pipeline with no shared unit; the ready path is combinational
// from dst_ready.
// Reset: arst_n clears both pipeline valids and sets the layout to 8888.
// Stall: while dst_ready is low the result word holds, the input register
// still fills once, and src_ready then drops until the result is taken.
module texel_format_to_bgra8 (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_ready,
	input  tfbgra_pkg::pixel_in_t  src_data,
	output logic                   dst_valid,
	input  logic                   dst_ready,
	output tfbgra_pkg::pixel_out_t dst_data,
	input  logic                   fmt_we,
	input  logic [tfbgra_pkg::FMT_W-1:0] fmt_wdata
);

	logic [tfbgra_pkg::FMT_W-1:0] fmt_q;
	tfbgra_pkg::pixel_in_t        word_s1;
	logic                         vld_s1;
	tfbgra_pkg::pixel_out_t       word_s2;
	logic                         vld_s2;
	logic                         adv_s2;
	logic                         adv_s1;
	tfbgra_pkg::pixel_out_t       res;
	logic [7:0]                   b0, b1, b2, b3;
	logic [15:0]                  w16;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= tfbgra_pkg::FMT_8888;
		end else if (fmt_we) begin
			fmt_q <= fmt_wdata;
		end
	end

	// pipeline flow control
	assign adv_s2    = !vld_s2 || dst_ready;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign src_ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && src_valid) begin
			word_s1 <= src_data;
		end
	end

	// byte split of the held pixel
	assign b0  = word_s1.pixel_bytes[7:0];
	assign b1  = word_s1.pixel_bytes[15:8];
	assign b2  = word_s1.pixel_bytes[23:16];
	assign b3  = word_s1.pixel_bytes[31:24];
	assign w16 = word_s1.pixel_bytes[15:0];

	// unpack by layout
	always_comb begin
		res              = '0;
		res.last_out     = word_s1.last_in;
		case (fmt_q)
			tfbgra_pkg::FMT_8888: begin
				res.blue = b0; res.green = b1; res.red = b2; res.alpha = b3;
				res.bytes_used = 3'd4;
			end
			tfbgra_pkg::FMT_X888: begin
				res.blue = b0; res.green = b1; res.red = b2; res.alpha = 8'hff;
				res.bytes_used = 3'd4;
			end
			tfbgra_pkg::FMT_888: begin
				res.blue = b0; res.green = b1; res.red = b2; res.alpha = 8'hff;
				res.bytes_used = 3'd3;
			end
			tfbgra_pkg::FMT_565: begin
				res.blue  = tfbgra_pkg::rep5(w16[4:0]);
				res.green = tfbgra_pkg::scale6(w16[10:5]);
				res.red   = tfbgra_pkg::rep5(w16[15:11]);
				res.alpha = 8'hff;
				res.bytes_used = 3'd2;
			end
			tfbgra_pkg::FMT_X555, tfbgra_pkg::FMT_1555: begin
				res.blue  = tfbgra_pkg::rep5(w16[4:0]);
				res.green = tfbgra_pkg::rep5(w16[9:5]);
				res.red   = tfbgra_pkg::rep5(w16[14:10]);
				res.alpha = (fmt_q == tfbgra_pkg::FMT_1555 && !w16[15]) ? 8'h00 : 8'hff;
				res.bytes_used = 3'd2;
			end
			tfbgra_pkg::FMT_4444, tfbgra_pkg::FMT_X444: begin
				res.blue  = tfbgra_pkg::rep4(w16[3:0]);
				res.green = tfbgra_pkg::rep4(w16[7:4]);
				res.red   = tfbgra_pkg::rep4(w16[11:8]);
				res.alpha = (fmt_q == tfbgra_pkg::FMT_4444) ?
					tfbgra_pkg::rep4(w16[15:12]) : 8'hff;
				res.bytes_used = 3'd2;
			end
			tfbgra_pkg::FMT_A8: begin
				res.blue = 8'hff; res.green = 8'hff; res.red = 8'hff; res.alpha = b0;
				res.bytes_used = 3'd1;
			end
			tfbgra_pkg::FMT_L8: begin
				res.blue = b0; res.green = b0; res.red = b0; res.alpha = 8'hff;
				res.bytes_used = 3'd1;
			end
			tfbgra_pkg::FMT_A8L8: begin
				res.blue = b0; res.green = b0; res.red = b0; res.alpha = b1;
				res.bytes_used = 3'd2;
			end
			tfbgra_pkg::FMT_A4L4: begin
				res.blue  = tfbgra_pkg::rep4(b0[3:0]);
				res.green = tfbgra_pkg::rep4(b0[3:0]);
				res.red   = tfbgra_pkg::rep4(b0[3:0]);
				res.alpha = tfbgra_pkg::rep4(b0[7:4]);
				res.bytes_used = 3'd1;
			end
			tfbgra_pkg::FMT_332, tfbgra_pkg::FMT_A8_332: begin
				res.blue  = tfbgra_pkg::scale2(b0[1:0]);
				res.green = tfbgra_pkg::scale3(b0[4:2]);
				res.red   = tfbgra_pkg::scale3(b0[7:5]);
				res.alpha = (fmt_q == tfbgra_pkg::FMT_A8_332) ? b1 : 8'hff;
				res.bytes_used = (fmt_q == tfbgra_pkg::FMT_A8_332) ? 3'd2 : 3'd1;
			end
			default: begin
				res.format_error = 1'b1;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			word_s2 <= res;
		end
	end

	assign dst_valid = vld_s2;
	assign dst_data  = word_s2;

	// checks
	a_err_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && adv_s2 && (fmt_q > tfbgra_pkg::FMT_A8_332)) |=> dst_data.format_error)
		else $error("unsupported format not flagged");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_data.format_error) |->
		(dst_data.bytes_used == 3'd0 && dst_data.blue == 8'd0 && dst_data.alpha == 8'd0))
		else $error("error word carries data");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && !dst_data.format_error) |->
		(dst_data.bytes_used != 3'd0 && dst_data.bytes_used <= 3'd4))
		else $error("byte count out of range");

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready) |=> vld_s1)
		else $error("accepted word lost at input register");

	a_move_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !vld_s2) |=> vld_s2)
		else $error("held word not moved to result register");

endmodule

// ===== tb/tb.sv =====
// testbench for texel_format_to_bgra8: scoreboard of unpacked bgra words across every layout
`timescale 1ns / 100ps

module tb;

	localparam int IDLE_PCT     = 18;
	localparam int REPORT_LIMIT = 10;
	localparam int SETTLE_CYC   = 4;

	logic                   clk;
	logic                   arst_n;
	logic                   src_valid;
	logic                   src_ready;
	tfbgra_pkg::pixel_in_t  src_data;
	logic                   dst_valid;
	logic                   dst_ready;
	tfbgra_pkg::pixel_out_t dst_data;
	logic                   fmt_we;
	logic [tfbgra_pkg::FMT_W-1:0] fmt_wdata;

	// model copy of the layout register
	logic [3:0] layout_sel;
	// no idling on either side while set
	bit         steady_flow;
	tfbgra_pkg::pixel_out_t pending_texels[$];
	int         mismatch_count;

	texel_format_to_bgra8 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.fmt_we    (fmt_we),
		.fmt_wdata (fmt_wdata)
	);

	// clock
	always #5 clk = ~clk;

	// narrow channel to byte by repeating its bits from the top down
	function automatic logic [7:0] fill_bits(input logic [7:0] v, input int width);
		logic [7:0] r;
		for (int i = 7; i >= 0; i--)
			r[i] = v[width - 1 - ((7 - i) % width)];
		return r;
	endfunction

	// narrow channel to byte as floor(v * 255 / full)
	function automatic logic [7:0] stretch(input int unsigned v, input int unsigned full);
		int unsigned q;
		q = (v * 255) / full;
		return q[7:0];
	endfunction

	// expected bgra word for one source pixel under the given layout
	function automatic tfbgra_pkg::pixel_out_t expand_texel(input logic [3:0] fmt,
			input tfbgra_pkg::pixel_in_t px);
		tfbgra_pkg::pixel_out_t r;
		logic [7:0]  b0, b1, b2, b3;
		logic [15:0] w;
		r  = '0;
		b0 = px.pixel_bytes[7:0];
		b1 = px.pixel_bytes[15:8];
		b2 = px.pixel_bytes[23:16];
		b3 = px.pixel_bytes[31:24];
		w  = px.pixel_bytes[15:0];
		r.last_out = px.last_in;
		case (fmt)
			tfbgra_pkg::FMT_8888, tfbgra_pkg::FMT_X888, tfbgra_pkg::FMT_888: begin
				r.blue  = b0;
				r.green = b1;
				r.red   = b2;
				r.alpha = (fmt == tfbgra_pkg::FMT_8888) ? b3 : 8'hff;
				r.bytes_used = (fmt == tfbgra_pkg::FMT_888) ? 3'd3 : 3'd4;
			end
			tfbgra_pkg::FMT_565: begin
				r.blue  = fill_bits({3'd0, w[4:0]}, 5);
				r.green = stretch(32'(w[10:5]), 63);
				r.red   = fill_bits({3'd0, w[15:11]}, 5);
				r.alpha = 8'hff;
				r.bytes_used = 3'd2;
			end
			tfbgra_pkg::FMT_X555, tfbgra_pkg::FMT_1555: begin
				r.blue  = fill_bits({3'd0, w[4:0]}, 5);
				r.green = fill_bits({3'd0, w[9:5]}, 5);
				r.red   = fill_bits({3'd0, w[14:10]}, 5);
				r.alpha = (fmt == tfbgra_pkg::FMT_1555 && !w[15]) ? 8'h00 : 8'hff;
				r.bytes_used = 3'd2;
			end
			tfbgra_pkg::FMT_4444, tfbgra_pkg::FMT_X444: begin
				r.blue  = fill_bits({4'd0, w[3:0]}, 4);
				r.green = fill_bits({4'd0, w[7:4]}, 4);
				r.red   = fill_bits({4'd0, w[11:8]}, 4);
				r.alpha = (fmt == tfbgra_pkg::FMT_4444) ?
					fill_bits({4'd0, w[15:12]}, 4) : 8'hff;
				r.bytes_used = 3'd2;
			end
			tfbgra_pkg::FMT_A8: begin
				r.blue  = 8'hff;
				r.green = 8'hff;
				r.red   = 8'hff;
				r.alpha = b0;
				r.bytes_used = 3'd1;
			end
			tfbgra_pkg::FMT_L8, tfbgra_pkg::FMT_A8L8: begin
				r.blue  = b0;
				r.green = b0;
				r.red   = b0;
				r.alpha = (fmt == tfbgra_pkg::FMT_A8L8) ? b1 : 8'hff;
				r.bytes_used = (fmt == tfbgra_pkg::FMT_A8L8) ? 3'd2 : 3'd1;
			end
			tfbgra_pkg::FMT_A4L4: begin
				r.blue  = fill_bits({4'd0, b0[3:0]}, 4);
				r.green = r.blue;
				r.red   = r.blue;
				r.alpha = fill_bits({4'd0, b0[7:4]}, 4);
				r.bytes_used = 3'd1;
			end
			tfbgra_pkg::FMT_332, tfbgra_pkg::FMT_A8_332: begin
				r.blue  = stretch(32'(b0[1:0]), 3);
				r.green = stretch(32'(b0[4:2]), 7);
				r.red   = stretch(32'(b0[7:5]), 7);
				r.alpha = (fmt == tfbgra_pkg::FMT_A8_332) ? b1 : 8'hff;
				r.bytes_used = (fmt == tfbgra_pkg::FMT_A8_332) ? 3'd2 : 3'd1;
			end
			default: begin
				r.format_error = 1'b1;
			end
		endcase
		return r;
	endfunction

	// random pixel, now and then an all-zero or all-one word
	function automatic tfbgra_pkg::pixel_in_t random_pixel();
		tfbgra_pkg::pixel_in_t px;
		case ($urandom_range(15))
			0:       px.pixel_bytes = 32'h0000_0000;
			1:       px.pixel_bytes = 32'hffff_ffff;
			default: px.pixel_bytes = $urandom;
		endcase
		px.last_in = 1'($urandom_range(1));
		return px;
	endfunction

	// result side back-pressure
	always @(negedge clk) begin
		dst_ready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
	end

	// compare each result word with the oldest expected one
	always @(posedge clk) begin
		tfbgra_pkg::pixel_out_t want;
		if (arst_n && dst_valid && dst_ready) begin
			if (pending_texels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: result word with nothing expected: %p", $realtime, dst_data);
			end else begin
				want = pending_texels.pop_front();
				if (dst_data.blue !== want.blue || dst_data.green !== want.green ||
						dst_data.red !== want.red || dst_data.alpha !== want.alpha ||
						dst_data.bytes_used !== want.bytes_used ||
						dst_data.format_error !== want.format_error ||
						dst_data.last_out !== want.last_out) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: mismatch, expected %p, got %p", $realtime, want, dst_data);
				end
			end
		end
	end

	// offer one pixel word and hold it until taken
	task automatic send_pixel(input tfbgra_pkg::pixel_in_t px);
		@(negedge clk);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			src_valid = 1'b0;
			@(negedge clk);
		end
		src_valid = 1'b1;
		src_data  = px;
		do @(posedge clk); while (!src_ready);
		pending_texels.push_back(expand_texel(layout_sel, px));
	endtask

	// stop sending and wait for every expected word to come back
	task automatic drain_words();
		@(negedge clk);
		src_valid = 1'b0;
		while (pending_texels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// layout register write, only with the pipeline empty
	task automatic set_layout(input logic [3:0] fmt);
		drain_words();
		@(negedge clk);
		fmt_we    = 1'b1;
		fmt_wdata = fmt;
		@(negedge clk);
		fmt_we     = 1'b0;
		layout_sel = fmt;
	endtask

	// register value after reset, then one word per layout and the edge cases
	task automatic test_directed();
		tfbgra_pkg::pixel_in_t px;
		send_pixel('{pixel_bytes: 32'h0000_0000, last_in: 1'b0});
		send_pixel('{pixel_bytes: 32'hffff_ffff, last_in: 1'b1});
		for (int f = 0; f < 16; f++) begin
			set_layout(f[3:0]);
			px.pixel_bytes = f[0] ? 32'ha55a_c33c : 32'hffff_ffff;
			px.last_in     = f[1];
			send_pixel(px);
		end
		// 1555 with the alpha bit clear and the unused bytes set
		set_layout(tfbgra_pkg::FMT_1555);
		send_pixel('{pixel_bytes: 32'hffff_7fff, last_in: 1'b0});
		// 565 green at the rounding steps of the stretch
		set_layout(tfbgra_pkg::FMT_565);
		send_pixel('{pixel_bytes: 32'h0000_02a0, last_in: 1'b1});
		send_pixel('{pixel_bytes: 32'h0000_0540, last_in: 1'b0});
	endtask

	// random pixels under every layout in a scrambled order
	task automatic test_random_layouts();
		int start;
		start = $urandom_range(15);
		for (int i = 0; i < 16; i++) begin
			set_layout(4'((i * 7 + start) % 16));
			repeat (38) send_pixel(random_pixel());
		end
	endtask

	// back to back words with neither side idling
	task automatic test_full_rate();
		set_layout(4'($urandom_range(15)));
		steady_flow = 1'b1;
		repeat (100) send_pixel(random_pixel());
		drain_words();
		steady_flow = 1'b0;
	endtask

	// sender holds off until the pipeline is empty, then resumes
	task automatic test_sender_pause();
		set_layout(tfbgra_pkg::FMT_A8_332);
		repeat (20) send_pixel(random_pixel());
		drain_words();
		repeat (20) send_pixel(random_pixel());
		set_layout(tfbgra_pkg::FMT_8888);
		repeat (10) send_pixel(random_pixel());
	endtask

	// stimulus sequence
	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		src_valid      = 1'b0;
		src_data       = '0;
		fmt_we         = 1'b0;
		fmt_wdata      = '0;
		layout_sel     = tfbgra_pkg::FMT_8888;
		steady_flow    = 1'b0;
		mismatch_count = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_layouts();
		test_full_rate();
		test_sender_pause();
		drain_words();

		if (mismatch_count == 0) begin
			$display("texel_format_to_bgra8 verification clean");
		end else begin
			$display("texel_format_to_bgra8 verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("texel_format_to_bgra8 verification failed");
		$finish;
	end

endmodule
